// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Clocked assertion shorthands shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// expression never true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// File: hdl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Token and result types, codes and precedence for the postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam logic [2:0] TK_OPERAND = 3'd0;
	localparam logic [2:0] TK_LPAREN  = 3'd1;
	localparam logic [2:0] TK_RPAREN  = 3'd2;
	localparam logic [2:0] TK_OPER    = 3'd3;
	localparam logic [2:0] TK_END     = 3'd4;

	localparam logic [1:0] OK_OPERAND  = 2'd0;
	localparam logic [1:0] OK_OPERATOR = 2'd1;
	localparam logic [1:0] OK_PAREN    = 2'd2;
	localparam logic [1:0] OK_ERROR    = 2'd3;

	localparam logic [2:0] OP_AND = 3'd6;
	localparam logic [2:0] OP_OR  = 3'd7;

	localparam logic [3:0] PAREN_ENTRY = 4'd8;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  oper_code;
		logic [31:0] operand_value;
	} tok_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [2:0]  out_oper_code;
		logic [31:0] out_operand_value;
		logic        last;
	} pf_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] kind;
		logic       last;
		logic       push;
		logic       pop;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] code;
		logic [3:0] tos;
		logic [3:0] below;
		logic       empty;
		logic       one;
		logic       full;
		logic       out_free;
	} sts_t;

	function automatic logic [1:0] rank_of(input logic [2:0] code);
		logic [1:0] r;
		if (code == OP_OR) begin
			r = 2'd1;
		end else if (code == OP_AND) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

endpackage

// File: hdl/i2p_datapath.sv
// ----------------------------------------------------------------------------
// i2p_datapath
// Token register, operator stack with top-of-stack register, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2p_datapath #(
	parameter int STACK_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  i2p_pkg::tok_t  tok,
	input  i2p_pkg::cmd_t  cmd,
	output i2p_pkg::sts_t  sts,
	output logic           pf_valid,
	input  logic           pf_stall,
	output i2p_pkg::pf_t   pf
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [2:0]    kind_q;
	logic [2:0]    code_q;
	logic [31:0]   value_q;
	logic [CW-1:0] count_q;
	logic [3:0]    tos_q;
	logic [3:0]    rd_q;
	logic [3:0]    mem [STACK_DEPTH];
	logic          pf_valid_q;
	i2p_pkg::pf_t  pf_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [3:0]    push_entry;

	assign cnt_m1     = count_q - CW'(1);
	assign cnt_m2     = count_q - CW'(2);
	assign push_entry = (kind_q == i2p_pkg::TK_LPAREN) ? i2p_pkg::PAREN_ENTRY
		: {1'b0, code_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= tok.op;
			code_q  <= tok.oper_code;
			value_q <= tok.operand_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tos_q <= push_entry;
		end else if (cmd.pop) begin
			tos_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && count_q != '0) begin
			mem[cnt_m1[AW-1:0]] <= tos_q;
		end
		rd_q <= mem[cnt_m2[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			pf_valid_q <= 1'b1;
		end else if (!pf_stall) begin
			pf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pf_q.out_kind          <= cmd.kind;
			pf_q.out_oper_code     <= (cmd.kind == i2p_pkg::OK_OPERATOR) ? tos_q[2:0] : 3'd0;
			pf_q.out_operand_value <= (cmd.kind == i2p_pkg::OK_OPERAND) ? value_q : 32'd0;
			pf_q.last              <= cmd.last;
		end
	end

	assign pf_valid = pf_valid_q;
	assign pf       = pf_q;

	always_comb begin
		sts.kind     = kind_q;
		sts.code     = code_q;
		sts.tos      = tos_q;
		sts.below    = rd_q;
		sts.empty    = (count_q == '0);
		sts.one      = (count_q == CW'(1));
		sts.full     = (count_q == CW'(STACK_DEPTH));
		sts.out_free = !pf_valid_q || !pf_stall;
	end

	`ASSERT_CLK(a_count_range, clk, arst_n, count_q <= CW'(STACK_DEPTH))
	`ASSERT_NEVER(a_push_full, clk, arst_n, cmd.push && count_q == CW'(STACK_DEPTH))

endmodule

// File: hdl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: accepts a token, then pushes, pops and emits one step at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2p_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	output logic           tok_stall,
	input  i2p_pkg::sts_t  sts,
	output i2p_pkg::cmd_t  cmd
);

	i2p_pkg::state_t state_q;
	i2p_pkg::state_t state_d;

	logic       accept;
	logic       act_emit;
	logic       act_pop;
	logic       act_push;
	logic       act_done;
	logic [1:0] act_kind;
	logic       act_last;
	logic       go;
	logic       tos_paren;
	logic       below_paren;
	logic       can_pop;

	assign accept      = (state_q == i2p_pkg::ST_IDLE) && tok_valid;
	assign tos_paren   = (sts.tos == i2p_pkg::PAREN_ENTRY);
	assign below_paren = (sts.below == i2p_pkg::PAREN_ENTRY);
	assign can_pop     = !sts.empty && !tos_paren &&
		(i2p_pkg::rank_of(sts.tos[2:0]) >= i2p_pkg::rank_of(sts.code));

	always_comb begin
		act_emit = 1'b0;
		act_pop  = 1'b0;
		act_push = 1'b0;
		act_done = 1'b0;
		act_kind = i2p_pkg::OK_OPERAND;
		act_last = 1'b0;
		unique case (sts.kind)
			i2p_pkg::TK_OPERAND: begin
				act_emit = 1'b1;
				act_last = 1'b1;
				act_done = 1'b1;
			end
			i2p_pkg::TK_LPAREN: begin
				act_done = 1'b1;
				if (sts.full) begin
					act_emit = 1'b1;
					act_kind = i2p_pkg::OK_ERROR;
					act_last = 1'b1;
				end else begin
					act_push = 1'b1;
				end
			end
			i2p_pkg::TK_RPAREN: begin
				if (sts.empty) begin
					act_done = 1'b1;
				end else if (tos_paren) begin
					act_pop  = 1'b1;
					act_done = 1'b1;
				end else begin
					act_emit = 1'b1;
					act_pop  = 1'b1;
					act_kind = i2p_pkg::OK_OPERATOR;
					act_last = sts.one || below_paren;
				end
			end
			i2p_pkg::TK_OPER: begin
				if (can_pop) begin
					act_emit = 1'b1;
					act_pop  = 1'b1;
					act_kind = i2p_pkg::OK_OPERATOR;
					act_last = sts.one || below_paren ||
						(i2p_pkg::rank_of(sts.below[2:0]) < i2p_pkg::rank_of(sts.code));
				end else if (sts.full) begin
					act_emit = 1'b1;
					act_kind = i2p_pkg::OK_ERROR;
					act_last = 1'b1;
					act_done = 1'b1;
				end else begin
					act_push = 1'b1;
					act_done = 1'b1;
				end
			end
			i2p_pkg::TK_END: begin
				if (sts.empty) begin
					act_done = 1'b1;
				end else begin
					act_emit = 1'b1;
					act_pop  = 1'b1;
					act_kind = tos_paren ? i2p_pkg::OK_PAREN : i2p_pkg::OK_OPERATOR;
					act_last = sts.one;
				end
			end
			default: begin
				act_done = 1'b1;
			end
		endcase
	end

	assign go = !act_emit || sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2p_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = i2p_pkg::ST_PROC;
				end
			end
			i2p_pkg::ST_PROC: begin
				if (go) begin
					state_d = act_done ? i2p_pkg::ST_IDLE : i2p_pkg::ST_WAIT;
				end
			end
			i2p_pkg::ST_WAIT: begin
				state_d = i2p_pkg::ST_PROC;
			end
			default: begin
				state_d = i2p_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2p_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		tok_stall = (state_q != i2p_pkg::ST_IDLE);
		cmd.load  = accept;
		cmd.emit  = 1'b0;
		cmd.push  = 1'b0;
		cmd.pop   = 1'b0;
		cmd.kind  = act_kind;
		cmd.last  = act_last;
		if (state_q == i2p_pkg::ST_PROC && go) begin
			cmd.emit = act_emit;
			cmd.push = act_push;
			cmd.pop  = act_pop;
		end
	end

	`ASSERT_CLK(a_emit_room, clk, arst_n, cmd.emit |-> sts.out_free)
	`ASSERT_CLK(a_pop_nonempty, clk, arst_n, cmd.pop |-> !sts.empty)
	`ASSERT_CLK(a_accept_proc, clk, arst_n, accept |=> state_q == i2p_pkg::ST_PROC)

endmodule

// File: hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of classified tokens into postfix order.
// ----------------------------------------------------------------------------
// channel  handshake             payload
// tok      tok_valid/tok_stall   i2p_pkg::tok_t
// pf       pf_valid/pf_stall     i2p_pkg::pf_t
//
// A token is accepted in the idle state, then handled one push, pop or
// silent step at a time. A pop that does not finish the token passes
// through the wait state: the stack RAM read of the next entry below the
// top-of-stack register must settle after every pop.
// Reset clears the stack count and the output valid flag; no clearing pass.
// A stalled result holds in the output register; the sequencer waits there.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	output logic          tok_stall,
	input  i2p_pkg::tok_t tok,
	output logic          pf_valid,
	input  logic          pf_stall,
	output i2p_pkg::pf_t  pf
);

	i2p_pkg::cmd_t cmd;
	i2p_pkg::sts_t sts;

	i2p_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	i2p_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (tok),
		.cmd      (cmd),
		.sts      (sts),
		.pf_valid (pf_valid),
		.pf_stall (pf_stall),
		.pf       (pf)
	);

endmodule
